@@ rtl/tti_pkg.sv @@
// ----------------------------------------------------------------------------
// Text to integer parser package
// Shared types, parse phase codes and character constants.
// ----------------------------------------------------------------------------
package tti_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Character codes the parser looks for.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Digit code for a character that is no digit at all.
  localparam logic [4:0] DIGIT_NONE = 5'd31;

  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
    logic        neg;
    logic [4:0]  base;
    logic [15:0] count;
  } tti_state_t;

  localparam tti_state_t STATE_CLEAR = '{
    phase: PH_WS, acc: 64'd0, neg: 1'b0, base: 5'd0, count: 16'd0
  };

  // Result of one parser step.
  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    logic [15:0] offset;
  } tti_result_t;

endpackage

@@ rtl/tti_ifs.sv @@
// ----------------------------------------------------------------------------
// Text to integer parser channels
// Valid/ready channels for characters in and parsed integers out.
// ----------------------------------------------------------------------------
interface tti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       string_start;

  modport source (output valid, output char_code, output string_start, input ready);
  modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

interface tti_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] parsed_value;
  logic        [15:0] end_offset;

  modport source (output valid, output parsed_value, output end_offset, input ready);
  modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

@@ rtl/tti_step.sv @@
// ----------------------------------------------------------------------------
// Text to integer parser step
// Combinational next state and result for one character.
// ----------------------------------------------------------------------------
module tti_step
  import tti_pkg::*;
(
  input  tti_state_t  cur_state,
  input  logic [7:0]  char_code,
  input  logic        string_start,
  input  logic [4:0]  cfg_base,
  input  logic [15:0] count_limit,
  output tti_state_t  nxt_state,
  output tti_result_t result
);

  logic       is_space;
  logic [4:0] digit;

  // Character classification.
  always_comb begin
    is_space = (char_code == CH_SPACE) ||
               ((char_code >= CH_TAB) && (char_code <= CH_CR));
    if ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) begin
      digit = 5'(char_code - CH_ZERO);
    end else if ((char_code >= CH_LO_A) && (char_code <= CH_LO_F)) begin
      digit = 5'(char_code - CH_LO_A + 8'd10);
    end else if ((char_code >= CH_UP_A) && (char_code <= CH_UP_F)) begin
      digit = 5'(char_code - CH_UP_A + 8'd10);
    end else begin
      digit = DIGIT_NONE;
    end
  end

  // Walk through the phases; a phase that does not take the character
  // hands it on to the next one in the same cycle.
  always_comb begin
    tti_state_t st;
    logic [2:0] ph;
    logic       done;
    logic       bump;

    st   = string_start ? STATE_CLEAR : cur_state;
    ph   = st.phase;
    done = 1'b0;
    bump = 1'b0;
    result = '{valid: 1'b0, value: 64'd0, offset: 16'd0};

    if (ph == PH_WS) begin
      if (is_space) begin
        bump = 1'b1;
        done = 1'b1;
      end else if ((char_code == CH_MINUS) || (char_code == CH_PLUS)) begin
        st.neg   = (char_code == CH_MINUS);
        st.phase = PH_PREFIX;
        bump     = 1'b1;
        done     = 1'b1;
      end else begin
        ph = PH_PREFIX;
      end
    end

    if (!done && (ph == PH_PREFIX)) begin
      if ((char_code == CH_ZERO) && ((cfg_base == BASE_AUTO) || (cfg_base == BASE_HEX))) begin
        st.acc   = 64'd0;
        st.base  = (cfg_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        st.phase = PH_ZERO;
        bump     = 1'b1;
        done     = 1'b1;
      end else begin
        st.base = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
        ph      = PH_DIGITS;
      end
    end

    if (!done && (ph == PH_ZERO)) begin
      if ((char_code == CH_LO_X) || (char_code == CH_UP_X)) begin
        st.base  = BASE_HEX;
        st.phase = PH_DIGITS;
        bump     = 1'b1;
        done     = 1'b1;
      end else begin
        ph = PH_DIGITS;
      end
    end

    if (!done && (ph == PH_DIGITS)) begin
      if (digit < st.base) begin
        st.acc   = (st.acc * {59'd0, st.base}) + {59'd0, digit};
        st.phase = PH_DIGITS;
        bump     = 1'b1;
      end else begin
        result.valid  = 1'b1;
        result.value  = st.neg ? (64'd0 - st.acc) : st.acc;
        result.offset = st.count;
        st.phase      = PH_DONE;
      end
    end

    // Consumed character count saturates at the limit.
    if (bump && (st.count < count_limit)) begin
      st.count = st.count + 16'd1;
    end

    nxt_state = st;
  end

endmodule

@@ rtl/text_to_integer_parser.sv @@
// ----------------------------------------------------------------------------
// Text to integer parser
// Streaming signed integer parser, one character per transaction.
// Each result is computed from the character in the input register and registered.
// Throughput: one character per cycle unless a result waits; the single step
// loop over the parser state (classify, 64 by 5 bit multiply, add) sets it.
// Reset: synchronous active-low rst_n empties both stages, sets base to auto
// and puts the parser in the whitespace phase.
// ----------------------------------------------------------------------------
module text_to_integer_parser
  import tti_pkg::*;
#(
  parameter int unsigned MAX_OFFSET = 32'd65535
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  tti_in_if.sink     in_ch,
  tti_out_if.source  out_ch
);

  localparam logic [15:0] COUNT_LIMIT =
    (MAX_OFFSET > 32'd65535) ? 16'hFFFF : MAX_OFFSET[15:0];

  logic [4:0]  cfg_base_r;
  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_start_r;
  tti_state_t  state_r;
  tti_state_t  state_nxt;
  tti_result_t step_res;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [15:0] out_offset_r;
  logic        advance;

  // Base register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= BASE_AUTO;
    end else if (cfg_wr_en) begin
      cfg_base_r <= cfg_wr_data;
    end
  end

  tti_step u_step (
    .cur_state    (state_r),
    .char_code    (s1_char_r),
    .string_start (s1_start_r),
    .cfg_base     (cfg_base_r),
    .count_limit  (COUNT_LIMIT),
    .nxt_state    (state_nxt),
    .result       (step_res)
  );

  // The held character moves on unless it makes a result that has no room.
  assign advance     = s1_valid_r && (!step_res.valid || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char_r  <= in_ch.char_code;
      s1_start_r <= in_ch.string_start;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_value_r  <= step_res.value;
      out_offset_r <= step_res.offset;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parsed_value = out_value_r;
  assign out_ch.end_offset   = out_offset_r;

endmodule
